FILE: sv/psc_pkg.sv
`timescale 1ns / 1ps
package psc_pkg;

  localparam int unsigned REPLY_WORDS = 16;
  localparam int unsigned OFF_W       = $clog2(REPLY_WORDS);
  localparam logic [OFF_W-1:0] LAST_OFF = OFF_W'(REPLY_WORDS - 1);

  localparam logic [15:0] CMD_LCD        = 16'h0010;
  localparam logic [15:0] CMD_LCD_LED    = 16'h0018;
  localparam logic [15:0] LED_FLAG       = 16'h0014;
  localparam logic [15:0] LCD_RESET_WORD = 16'h0080;
  localparam logic [7:0]  FLAG_POS       = 8'd7;
  localparam logic [7:0]  LEVELS_RESET   = 8'hff;

  localparam logic OP_SPI    = 1'b0;
  localparam logic OP_BUTTON = 1'b1;

  // Fixed words of the reply frame
  localparam logic [15:0] RPL_ID0  = 16'h004d;  // 'M'
  localparam logic [15:0] RPL_ID1  = 16'h0057;  // 'W'
  localparam logic [15:0] RPL_ENC0 = 16'h0030;
  localparam logic [15:0] RPL_ENC1 = 16'h0038;
  localparam logic [15:0] RPL_VOL  = 16'h00ff;
  localparam logic [15:0] RPL_END  = 16'h0078;  // 'x'

  typedef struct packed {
    logic        operation;
    logic [7:0]  frame_position;
    logic [15:0] spi_word;
    logic [2:0]  button_number;
    logic        button_pressed;
    logic [4:0]  led_query;
    logic [2:0]  button_query;
  } item_t;

  typedef struct packed {
    logic [7:0]  button_levels;
    logic [15:0] current_command;
    logic        led_update_flag;
    logic [31:0] led_word;
  } state_t;

  typedef struct packed {
    logic             reply_valid;
    logic [OFF_W-1:0] reply_offset;
    logic [15:0]      reply_word;
    logic             lcd_char_valid;
    logic [7:0]       lcd_char;
    logic             lcd_position_reset;
    logic             leds_changed;
    logic             led_query_on;
    logic             button_query_down;
    logic             last;
  } result_t;

  function automatic logic [15:0] reply_at(input logic [OFF_W-1:0] idx,
                                           input logic [7:0] levels);
    logic [15:0] w;
    w = '0;
    case (idx)
      4'd0:    w = RPL_ID0;
      4'd1:    w = RPL_ID1;
      4'd2:    w = RPL_ENC0;
      4'd7:    w = RPL_ENC1;
      4'd12:   w = {10'd0, levels[5:0]};
      4'd13:   w = {10'd0, levels[6], 5'd0};
      4'd14:   w = RPL_VOL;
      4'd15:   w = RPL_END;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

FILE: sv/psc_step.sv
`timescale 1ns / 1ps
module psc_step (
  input  psc_pkg::item_t   item_i,
  input  psc_pkg::state_t  state_i,
  output psc_pkg::state_t  state_o,
  output psc_pkg::result_t res_o,
  output logic             burst_o
);
  import psc_pkg::*;

  logic [7:0]  byte_w;
  logic [7:0]  ch;
  logic        pres;
  logic        flag_new;
  logic        in_chars;
  logic        in_leds;
  logic [31:0] led_new;
  logic        frame_start;

  assign byte_w      = item_i.spi_word[7:0];
  assign frame_start = (item_i.operation == OP_SPI) && (item_i.frame_position == 8'd0);
  assign in_chars    = (item_i.frame_position >= 8'd1) && (item_i.frame_position <= 8'd6);
  assign in_leds     = (item_i.frame_position[7:2] == 6'd2);
  assign flag_new    = (item_i.frame_position == FLAG_POS) ? (item_i.spi_word == LED_FLAG)
                                                           : state_i.led_update_flag;

  always_comb begin
    led_new = state_i.led_word;
    case (item_i.frame_position[1:0])
      2'd0:    led_new[7:0]   = byte_w;
      2'd1:    led_new[15:8]  = byte_w;
      2'd2:    led_new[23:16] = byte_w;
      2'd3:    led_new[31:24] = byte_w;
      default: led_new = state_i.led_word;
    endcase
  end

  always_comb begin
    state_o = state_i;
    ch      = '0;
    pres    = 1'b0;
    if (item_i.operation == OP_BUTTON) begin
      state_o.button_levels[item_i.button_number] = ~item_i.button_pressed;
    end else if (frame_start) begin
      state_o.current_command = item_i.spi_word;
    end else if (state_i.current_command == CMD_LCD) begin
      if (item_i.frame_position == 8'd1) begin
        pres = (item_i.spi_word == LCD_RESET_WORD);
      end else begin
        ch = byte_w;
      end
    end else if (state_i.current_command == CMD_LCD_LED) begin
      state_o.led_update_flag = flag_new;
      if (flag_new) begin
        if (in_chars) begin
          ch = byte_w;
        end else if (in_leds) begin
          state_o.led_word = led_new;
        end
      end else begin
        ch = byte_w;
      end
    end
  end

  // Queries see the state after the step; a frame start leaves both untouched
  always_comb begin
    res_o                    = '0;
    res_o.lcd_char           = ch;
    res_o.lcd_char_valid     = (ch != 8'd0);
    res_o.lcd_position_reset = pres;
    res_o.leds_changed       = (state_o.led_word != state_i.led_word);
    res_o.led_query_on       = state_o.led_word[item_i.led_query];
    res_o.button_query_down  = ~state_o.button_levels[item_i.button_query];
    res_o.last               = 1'b1;
    if (frame_start) begin
      res_o.reply_valid  = 1'b1;
      res_o.reply_offset = '0;
      res_o.reply_word   = reply_at('0, state_i.button_levels);
      res_o.last         = 1'b0;
    end
  end

  assign burst_o = frame_start;

endmodule

FILE: sv/panel_spi_command_decoder_top.sv
`timescale 1ns / 1ps
// Front-panel command decoder. Each input word is an SPI word tagged with its
// frame position, or a button event (tuser high). Ordinary words and button
// events each give one result; a word at frame position 0 gives a 16-word
// reply burst, one word per cycle while the output side accepts, out of the
// single output register, and the input is held off until the last reply
// word is loaded. A word can be accepted while a finished result waits, as
// long as the output side takes it in the same cycle.
module panel_spi_command_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // frame_position[7:0], spi_word[23:8], button_number[26:24],
  // button_pressed[27], led_query[32:28], button_query[35:33], zero[39:36]
  input  logic [39:0] s_axis_tdata,
  // operation[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // reply_offset[3:0], reply_word[19:4], lcd_char_valid[20], lcd_char[28:21],
  // lcd_position_reset[29], leds_changed[30], led_query_on[31],
  // button_query_down[32], zero[39:33]
  output logic [39:0] m_axis_tdata,
  // reply_valid[0]
  output logic [0:0]  m_axis_tuser,
  output logic        m_axis_tlast
);
  import psc_pkg::*;

  item_t            item;
  state_t           state_q, state_d;
  result_t          step_res;
  result_t          res_q, res_d;
  logic             step_burst;
  logic             m_valid_q, m_valid_d;
  logic             burst_q, burst_d;
  logic [OFF_W-1:0] cnt_q, cnt_d;
  logic [7:0]       lvl_q, lvl_d;
  logic             ledq_q, ledq_d;
  logic             btnq_q, btnq_d;
  logic             slot_free;
  logic             s_acc;

  assign item.operation      = s_axis_tuser[0];
  assign item.frame_position = s_axis_tdata[7:0];
  assign item.spi_word       = s_axis_tdata[23:8];
  assign item.button_number  = s_axis_tdata[26:24];
  assign item.button_pressed = s_axis_tdata[27];
  assign item.led_query      = s_axis_tdata[32:28];
  assign item.button_query   = s_axis_tdata[35:33];

  psc_step u_step (
    .item_i  (item),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (step_res),
    .burst_o (step_burst)
  );

  assign slot_free     = !m_valid_q || m_axis_tready;
  assign s_axis_tready = slot_free && !burst_q;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    res_d     = res_q;
    burst_d   = burst_q;
    cnt_d     = cnt_q;
    lvl_d     = lvl_q;
    ledq_d    = ledq_q;
    btnq_d    = btnq_q;
    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (burst_q && slot_free) begin
      // advance the reply burst by one word
      m_valid_d                = 1'b1;
      res_d                    = '0;
      res_d.reply_valid        = 1'b1;
      res_d.reply_offset       = cnt_q;
      res_d.reply_word         = reply_at(cnt_q, lvl_q);
      res_d.led_query_on       = ledq_q;
      res_d.button_query_down  = btnq_q;
      res_d.last               = (cnt_q == LAST_OFF);
      cnt_d                    = cnt_q + OFF_W'(1);
      burst_d                  = (cnt_q != LAST_OFF);
    end else if (s_acc) begin
      m_valid_d = 1'b1;
      res_d     = step_res;
      if (step_burst) begin
        burst_d = 1'b1;
        cnt_d   = OFF_W'(1);
        lvl_d   = state_q.button_levels;
        ledq_d  = step_res.led_query_on;
        btnq_d  = step_res.button_query_down;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q                     <= 1'b0;
      burst_q                       <= 1'b0;
      cnt_q                         <= '0;
      state_q.button_levels         <= LEVELS_RESET;
      state_q.current_command       <= '0;
      state_q.led_update_flag       <= 1'b0;
      state_q.led_word              <= '0;
    end else begin
      m_valid_q <= m_valid_d;
      burst_q   <= burst_d;
      cnt_q     <= cnt_d;
      if (s_acc) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    lvl_q  <= lvl_d;
    ledq_q <= ledq_d;
    btnq_q <= btnq_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = res_q.reply_valid;
  assign m_axis_tlast  = res_q.last;
  assign m_axis_tdata  = {7'd0,
                          res_q.button_query_down,
                          res_q.led_query_on,
                          res_q.leds_changed,
                          res_q.lcd_position_reset,
                          res_q.lcd_char,
                          res_q.lcd_char_valid,
                          res_q.reply_word,
                          res_q.reply_offset};

`ifndef SYNTH
  a_no_accept_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_q |-> !s_axis_tready)
    else $error("input accepted during reply burst");

  a_frame_start_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && step_burst) |=> (burst_q && cnt_q == OFF_W'(1) && m_valid_q))
    else $error("frame start did not open a reply burst");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !res_q.reply_valid) |-> res_q.last)
    else $error("single result without last");

  a_burst_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && res_q.reply_valid) |-> (res_q.last == (res_q.reply_offset == LAST_OFF)))
    else $error("reply burst last misplaced");

  a_burst_no_lcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && res_q.reply_valid) |->
      (!res_q.lcd_char_valid && !res_q.lcd_position_reset && !res_q.leds_changed))
    else $error("reply word carries LCD or LED activity");
`endif

endmodule
